// ===== rtl/vapr_pkg.sv =====
package vapr_pkg;

  // One voice's ramp state as held in the state memory.
  typedef struct packed {
    logic        active;
    logic [6:0]  pan;
    logic [6:0]  target;
    logic        down;
    logic [6:0]  mag;
    logic [14:0] reload;
    logic [14:0] cnt;
  } vapr_entry_t;

  // Volume inputs handed from the control to the volume unit.
  typedef struct packed {
    logic [6:0] voice_vol;
    logic [6:0] master_vol;
    logic [6:0] prog_vol;
    logic [6:0] prog_pan;
    logic [6:0] tone_vol;
    logic [6:0] tone_pan;
  } vapr_vol_in_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_VOL,
    ST_DONE
  } vapr_state_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [6:0] PAN_TOP = 7'd127;
  localparam logic [6:0] PAN_MID = 7'd64;

  // Division by 0x3F01 is done as a multiply by a rounded-up reciprocal.
  // With a shift of 42 it is exact for every dividend below 2**28.
  localparam int unsigned  VOL_DIV_SHIFT = 42;
  localparam logic [28:0]  VOL_DIV_REC   =
    29'(((64'd1 << VOL_DIV_SHIFT) + 64'h3F00) / 64'h3F01);

endpackage

// ===== rtl/vapr_mem.sv =====
module vapr_mem #(
  parameter int DEPTH = 24,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  vapr_pkg::vapr_entry_t wr_data,
  output vapr_pkg::vapr_entry_t rd_data
);
  import vapr_pkg::*;

  vapr_entry_t mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  vapr_entry_t q_r;
  logic q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  // An entry never written reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== rtl/vapr_div.sv =====
module vapr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [14:0] dividend,
  input  logic [14:0] divisor,
  output logic        done,
  output logic [14:0] quo
);
  logic [15:0] rem_r;
  logic [14:0] quo_r;
  logic [14:0] dvs_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [15:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r[14:0], quo_r[14]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[13:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == 4'd0);
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd14;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/vapr_vol.sv =====
module vapr_vol (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  vapr_pkg::vapr_vol_in_t vin,
  input  logic [6:0]             pan,
  input  logic                   mono,
  output logic                   done,
  output logic [13:0]            left,
  output logic [13:0]            right
);
  import vapr_pkg::*;

  logic [27:0] a_r;
  logic [13:0] base_r;
  logic [13:0] l_r;
  logic [13:0] r_r;
  logic [6:0]  pan_r;
  logic [3:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [56:0] prod;
  logic [13:0] quo;

  function automatic logic [13:0] scale(input logic [13:0] v, input logic [6:0] f);
    logic [20:0] p;
    p = 21'(v) * 21'(f);
    return p[19:6];
  endfunction

  assign prod = 57'(a_r) * 57'(VOL_DIV_REC);
  assign quo  = prod[VOL_DIV_SHIFT +: 14];

  // One multiply per step: two volume products with a division each, then
  // the tone, program and ramp pan laws, then the mono merge.
  always_ff @(posedge clk) begin
    if (go) begin
      pan_r <= pan;
    end else if (busy_r) begin
      case (step_r)
        4'd0: a_r <= 28'(14'(vin.voice_vol * vin.master_vol));
        4'd1: a_r <= (a_r << 14) - a_r;
        4'd2: base_r <= quo;
        4'd3: a_r <= 28'(21'(base_r) * 21'(vin.prog_vol));
        4'd4: a_r <= a_r[20:0] * 28'(vin.tone_vol);
        4'd5: base_r <= quo;
        4'd6: begin
          if (vin.tone_pan >= PAN_MID) begin
            r_r <= base_r;
            l_r <= scale(base_r, PAN_TOP - vin.tone_pan);
          end else begin
            l_r <= base_r;
            r_r <= scale(base_r, vin.tone_pan);
          end
        end
        4'd7: begin
          if (vin.prog_pan >= PAN_MID) begin
            l_r <= scale(l_r, PAN_TOP - vin.prog_pan);
          end else begin
            r_r <= scale(r_r, vin.prog_pan);
          end
        end
        4'd8: begin
          if (pan_r >= PAN_MID) begin
            l_r <= scale(l_r, PAN_TOP - pan_r);
          end else begin
            r_r <= scale(r_r, pan_r);
          end
        end
        4'd9: begin
          if (mono) begin
            if (l_r >= r_r) begin
              r_r <= l_r;
            end else begin
              l_r <= r_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !go && busy_r && (step_r == 4'd9);
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd9) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done  = done_r;
  assign left  = l_r;
  assign right = r_r;

endmodule

// ===== rtl/voice_auto_pan_ramp_top.sv =====
// Per-voice pan ramp engine. Raise start with a command word while busy is
// low: a start command loads a voice's ramp, a tick advances it. Every
// command gives exactly one result word, shown for a single cycle with
// out_valid high; the receiver cannot stall it, so it must take the word in
// that cycle. A start that needs its step or interval uses the 15-bit
// bit-serial divider; a tick that steps the pan runs the ten-step volume
// multiply chain. The next command is taken in the cycle its predecessor's
// result is shown. cfg_wr_data written with cfg_wr_en selects mono mode;
// write it only while the block is idle.
module voice_auto_pan_ramp_top #(
  parameter int VOICES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [4:0]  in_voice,
  input  logic [6:0]  in_start_pan,
  input  logic [6:0]  in_end_pan,
  input  logic [14:0] in_duration,
  input  logic [6:0]  in_voice_vol,
  input  logic [6:0]  in_master_vol,
  input  logic [6:0]  in_prog_vol,
  input  logic [6:0]  in_prog_pan,
  input  logic [6:0]  in_tone_vol,
  input  logic [6:0]  in_tone_pan,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output logic        out_valid,
  output logic [4:0]  out_voice,
  output logic        out_vol_update,
  output logic [13:0] out_left_vol,
  output logic [13:0] out_right_vol,
  output logic [6:0]  out_pan_now,
  output logic        out_ramp_active
);
  import vapr_pkg::*;

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  vapr_state_t st_r, st_nxt;

  // Command word held for the whole operation.
  logic         cmd_r;
  logic [4:0]   voice_r;
  logic [6:0]   s_r;
  logic [6:0]   e_r;
  logic [14:0]  d_r;
  vapr_vol_in_t vin_r;
  logic         mono_r;

  logic [6:0]   res_pan_r, res_pan_nxt;
  logic         res_act_r, res_act_nxt;
  logic         upd_r, upd_nxt;
  logic         res_ld;

  logic         out_valid_r;
  logic [4:0]   out_voice_r;
  logic         out_upd_r;
  logic [13:0]  out_left_r;
  logic [13:0]  out_right_r;
  logic [6:0]   out_pan_r;
  logic         out_act_r;

  logic         accept;
  logic         in_range;
  logic [AW-1:0] addr;
  vapr_entry_t  rd_ent;
  vapr_entry_t  wr_ent;
  logic         mem_we;

  logic [6:0]   pan_span;
  logic         down;
  logic         short_ramp;
  logic         div_go, div_done;
  logic [14:0]  div_dvd, div_dvs, div_q;

  logic         vol_go, vol_done;
  logic [13:0]  vol_l, vol_r;

  logic [7:0]   sum_up;
  logic [7:0]   sum_dn;
  logic         hit;
  logic [6:0]   p_new;

  assign accept   = start && (st_r == ST_IDLE);
  assign busy     = (st_r != ST_IDLE);
  assign in_range = 32'(in_voice) < VOICES;
  assign addr     = AW'(voice_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      voice_r <= in_voice;
      s_r     <= in_start_pan;
      e_r     <= in_end_pan;
      d_r     <= in_duration;
      vin_r   <= '{voice_vol: in_voice_vol, master_vol: in_master_vol,
                   prog_vol: in_prog_vol, prog_pan: in_prog_pan,
                   tone_vol: in_tone_vol, tone_pan: in_tone_pan};
    end
  end

  vapr_mem #(
    .DEPTH (VOICES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (AW'(in_voice)),
    .wr_en   (mem_we),
    .wr_addr (addr),
    .wr_data (wr_ent),
    .rd_data (rd_ent)
  );

  // Ramp geometry. A short ramp (distance below duration) moves one unit
  // every duration/distance + 1 ticks; otherwise it moves distance/duration
  // units every tick.
  assign down       = s_r > e_r;
  assign pan_span   = down ? s_r - e_r : e_r - s_r;
  assign short_ramp = 15'(pan_span) < d_r;
  assign div_dvd    = short_ramp ? d_r : 15'(pan_span);
  assign div_dvs    = short_ramp ? 15'(pan_span) : d_r;

  vapr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_q)
  );

  // One tick step: move, and stop at the target once reached or passed.
  assign sum_up = {1'b0, rd_ent.pan} + {1'b0, rd_ent.mag};
  assign sum_dn = {1'b0, rd_ent.pan} - {1'b0, rd_ent.mag};
  assign hit    = rd_ent.down ?
                  ((rd_ent.pan < rd_ent.mag) || (sum_dn <= {1'b0, rd_ent.target})) :
                  (sum_up >= {1'b0, rd_ent.target});
  assign p_new  = hit ? rd_ent.target : (rd_ent.down ? sum_dn[6:0] : sum_up[6:0]);

  vapr_vol u_vol (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (vol_go),
    .vin   (vin_r),
    .pan   (p_new),
    .mono  (mono_r),
    .done  (vol_done),
    .left  (vol_l),
    .right (vol_r)
  );

  always_comb begin
    st_nxt      = st_r;
    mem_we      = 1'b0;
    wr_ent      = rd_ent;
    div_go      = 1'b0;
    vol_go      = 1'b0;
    res_ld      = 1'b0;
    res_pan_nxt = rd_ent.pan;
    res_act_nxt = rd_ent.active;
    upd_nxt     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            st_nxt = ST_READ;
          end else begin
            // Unknown voice: report an idle result with zero pan.
            res_ld      = 1'b1;
            res_pan_nxt = '0;
            res_act_nxt = 1'b0;
            st_nxt      = ST_DONE;
          end
        end
      end
      ST_READ: begin
        res_ld = 1'b1;
        if (cmd_r == CMD_START) begin
          if (s_r == e_r) begin
            st_nxt = ST_DONE;
          end else if (d_r == '0) begin
            // Zero duration jumps straight to the end point.
            mem_we      = 1'b1;
            wr_ent      = '{active: 1'b0, pan: e_r, target: e_r, down: 1'b0,
                            mag: '0, reload: '0, cnt: '0};
            res_pan_nxt = e_r;
            res_act_nxt = 1'b0;
            st_nxt      = ST_DONE;
          end else begin
            res_ld = 1'b0;
            div_go = 1'b1;
            st_nxt = ST_DIV;
          end
        end else if (!rd_ent.active) begin
          st_nxt = ST_DONE;
        end else if (rd_ent.cnt != '0) begin
          mem_we     = 1'b1;
          wr_ent.cnt = rd_ent.cnt - 15'd1;
          st_nxt     = ST_DONE;
        end else begin
          mem_we        = 1'b1;
          wr_ent.active = !hit;
          wr_ent.pan    = p_new;
          wr_ent.cnt    = rd_ent.reload;
          res_pan_nxt   = p_new;
          res_act_nxt   = !hit;
          upd_nxt       = 1'b1;
          vol_go        = 1'b1;
          st_nxt        = ST_VOL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we      = 1'b1;
          wr_ent      = '{active: 1'b1, pan: s_r, target: e_r, down: down,
                          mag: short_ramp ? 7'd1 : div_q[6:0],
                          reload: short_ramp ? div_q : '0,
                          cnt: short_ramp ? div_q : '0};
          res_ld      = 1'b1;
          res_pan_nxt = s_r;
          res_act_nxt = 1'b1;
          st_nxt      = ST_DONE;
        end
      end
      ST_VOL: begin
        if (vol_done) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mono_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r == ST_DONE);
      if (cfg_wr_en) begin
        mono_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_pan_r <= res_pan_nxt;
      res_act_r <= res_act_nxt;
      upd_r     <= upd_nxt;
    end
    // The result word is registered as the operation finishes.
    if (st_r == ST_DONE) begin
      out_voice_r <= voice_r;
      out_upd_r   <= upd_r;
      out_left_r  <= upd_r ? vol_l : '0;
      out_right_r <= upd_r ? vol_r : '0;
      out_pan_r   <= res_pan_r;
      out_act_r   <= res_act_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_voice       = out_voice_r;
  assign out_vol_update  = out_upd_r;
  assign out_left_vol    = out_left_r;
  assign out_right_vol   = out_right_r;
  assign out_pan_now     = out_pan_r;
  assign out_ramp_active = out_act_r;

endmodule

// ===== tb/sv/voice_auto_pan_ramp_checker.sv =====
`timescale 1ns / 1ps

module voice_auto_pan_ramp_checker #(
  parameter int VOICES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_cmd,
  input  logic [4:0]  in_voice,
  input  logic [6:0]  in_start_pan,
  input  logic [6:0]  in_end_pan,
  input  logic [14:0] in_duration,
  input  logic [6:0]  in_voice_vol,
  input  logic [6:0]  in_master_vol,
  input  logic [6:0]  in_prog_vol,
  input  logic [6:0]  in_prog_pan,
  input  logic [6:0]  in_tone_vol,
  input  logic [6:0]  in_tone_pan,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        out_valid,
  input  logic [4:0]  out_voice,
  input  logic        out_vol_update,
  input  logic [13:0] out_left_vol,
  input  logic [13:0] out_right_vol,
  input  logic [6:0]  out_pan_now,
  input  logic        out_ramp_active,
  output int          fail_count,
  output int          pending,
  output int          pan_steps
);
  import vapr_pkg::*;

  localparam int unsigned VOL_FULL = 32'h3FFF;
  localparam int unsigned VOL_DIV  = 32'h3F01;

  typedef struct packed {
    logic [4:0]  voice;
    logic        vol_update;
    logic [13:0] left_vol;
    logic [13:0] right_vol;
    logic [6:0]  pan_now;
    logic        ramp_active;
  } pan_word_t;

  pan_word_t   expected_words[$];
  logic        mono;
  logic        ramp_on   [VOICES];
  int          pan_pos   [VOICES];
  int          pan_goal  [VOICES];
  int          pan_delta [VOICES];
  int unsigned tick_reload[VOICES];
  int unsigned tick_left  [VOICES];

  function automatic int unsigned apply_law(int unsigned x, int unsigned f);
    return ((x & 32'hFFFF) * f) >> 6;
  endfunction

  function automatic void stereo_volumes(input int unsigned pan, output logic [13:0] lv,
                                         output logic [13:0] rv);
    int unsigned base, l, r;
    base = int'(in_voice_vol) * VOL_FULL * int'(in_master_vol) / VOL_DIV;
    base = base * int'(in_prog_vol) * int'(in_tone_vol) / VOL_DIV;
    if (in_tone_pan >= PAN_MID) begin
      r = base;
      l = apply_law(base, int'(PAN_TOP) - int'(in_tone_pan));
    end else begin
      l = base;
      r = apply_law(base, int'(in_tone_pan));
    end
    if (in_prog_pan >= PAN_MID) l = apply_law(l, int'(PAN_TOP) - int'(in_prog_pan));
    else r = apply_law(r, int'(in_prog_pan));
    if (pan >= PAN_MID) l = apply_law(l, int'(PAN_TOP) - pan);
    else r = apply_law(r, pan);
    if (mono) begin
      if ((l & 32'hFFFF) >= (r & 32'hFFFF)) r = l;
      else l = r;
    end
    lv = l[13:0];
    rv = r[13:0];
  endfunction

  // Advances the voice table by one command word and returns its result word.
  function automatic pan_word_t advance_ramp();
    pan_word_t w;
    int s, e, d, span, p, v;
    w = '0;
    v = int'(in_voice);
    w.voice = in_voice;
    if (v >= VOICES) return w;
    if (in_cmd == CMD_START) begin
      s = int'(in_start_pan);
      e = int'(in_end_pan);
      d = int'(in_duration);
      if (s != e) begin
        span = (s > e) ? s - e : e - s;
        ramp_on[v]  = 1'b1;
        pan_pos[v]  = s;
        pan_goal[v] = e;
        if (span < d) begin
          pan_delta[v]   = (e > s) ? 1 : -1;
          tick_reload[v] = d / span;
          tick_left[v]   = tick_reload[v];
        end else if (d == 0) begin
          pan_pos[v]     = e;
          ramp_on[v]     = 1'b0;
          pan_delta[v]   = 0;
          tick_reload[v] = 0;
          tick_left[v]   = 0;
        end else begin
          pan_delta[v]   = (e > s) ? span / d : -(span / d);
          tick_reload[v] = 0;
          tick_left[v]   = 0;
        end
      end
    end else if (ramp_on[v]) begin
      if (tick_left[v] > 0) begin
        tick_left[v]--;
      end else begin
        p = pan_pos[v] + pan_delta[v];
        if ((pan_delta[v] > 0 && p >= pan_goal[v]) ||
            (pan_delta[v] < 0 && p <= pan_goal[v])) begin
          p = pan_goal[v];
          ramp_on[v] = 1'b0;
        end
        if (p < 0) p = 0;
        if (p > 127) p = 127;
        pan_pos[v] = p;
        stereo_volumes(p, w.left_vol, w.right_vol);
        w.vol_update = 1'b1;
        tick_left[v] = tick_reload[v];
      end
    end
    w.pan_now     = pan_pos[v][6:0];
    w.ramp_active = ramp_on[v];
    return w;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    pan_word_t got, want;
    if (!rst_n) begin
      mono = 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        ramp_on[i] = 1'b0;
        pan_pos[i] = 0;
        pan_goal[i] = 0;
        pan_delta[i] = 0;
        tick_reload[i] = 0;
        tick_left[i] = 0;
      end
      expected_words.delete();
      fail_count <= 0;
      pan_steps <= 0;
    end else begin
      // Compare the outgoing word first: a new command may be taken in the
      // same cycle, and its prediction belongs behind this one.
      if (out_valid) begin
        got = '{out_voice, out_vol_update, out_left_vol, out_right_vol,
                out_pan_now, out_ramp_active};
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected: %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
          if (want.vol_update) pan_steps <= pan_steps + 1;
        end
      end
      if (cfg_wr_en) mono = cfg_wr_data;
      if (start && !busy) expected_words.push_back(advance_ramp());
    end
  end

endmodule

// ===== tb/sv/voice_auto_pan_ramp_top_tb.sv =====
`timescale 1ns / 1ps

module voice_auto_pan_ramp_top_tb;
  import vapr_pkg::*;

  localparam int VOICES = 24;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [4:0]  in_voice;
  logic [6:0]  in_start_pan;
  logic [6:0]  in_end_pan;
  logic [14:0] in_duration;
  logic [6:0]  in_voice_vol;
  logic [6:0]  in_master_vol;
  logic [6:0]  in_prog_vol;
  logic [6:0]  in_prog_pan;
  logic [6:0]  in_tone_vol;
  logic [6:0]  in_tone_pan;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        out_valid;
  logic [4:0]  out_voice;
  logic        out_vol_update;
  logic [13:0] out_left_vol;
  logic [13:0] out_right_vol;
  logic [6:0]  out_pan_now;
  logic        out_ramp_active;
  int          fail_count;
  int          pending;
  int          pan_steps;
  int          words_sent;
  int          burst_left;

  voice_auto_pan_ramp_top #(.VOICES(VOICES)) dut (.*);

  voice_auto_pan_ramp_checker #(.VOICES(VOICES)) u_checker (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Sends one command word: fields are set at the falling edge and held until
  // a rising edge sees busy low. Between words the sender idles in bursts, so
  // gaps land on every phase of a command's processing.
  task automatic send_word(input logic cmd, input logic [4:0] v, input logic [6:0] sp,
                           input logic [6:0] ep, input logic [14:0] dur);
    @(negedge clk);
    start         = 1'b1;
    in_cmd        = cmd;
    in_voice      = v;
    in_start_pan  = sp;
    in_end_pan    = ep;
    in_duration   = dur;
    // Volumes are random on every word; mostly full range, sometimes at the rails.
    in_voice_vol  = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom);
    in_master_vol = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom);
    in_prog_vol   = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom);
    in_tone_vol   = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom);
    in_prog_pan   = ($urandom_range(0, 5) == 0) ? PAN_MID : 7'($urandom);
    in_tone_pan   = ($urandom_range(0, 5) == 0) ? PAN_MID : 7'($urandom);
    do @(posedge clk); while (busy);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Mode changes only happen with the block idle: start is dropped and all
  // pending results are awaited before the mode is written.
  task automatic set_mono(input logic mode);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic tick_voice(input logic [4:0] v);
    send_word(CMD_TICK, v, 7'($urandom), 7'($urandom), 15'($urandom));
  endtask

  // A well-formed ramp: one start, then a random run of ticks on it. Short
  // durations dominate so many of the ramps actually finish.
  task automatic ramp_sequence();
    logic [4:0]  v;
    logic [14:0] dur;
    int          ticks;
    v = 5'($urandom_range(0, VOICES - 1));
    case ($urandom_range(0, 9))
      0:       dur = 15'($urandom);
      1, 2:    dur = 15'($urandom_range(0, 300));
      default: dur = 15'($urandom_range(0, 24));
    endcase
    send_word(CMD_START, v, 7'($urandom), 7'($urandom), dur);
    ticks = $urandom_range(1, 40);
    for (int i = 0; i < ticks; i++) begin
      // Mostly the ramped voice, now and then another voice interleaves.
      if ($urandom_range(0, 5) == 0) tick_voice(5'($urandom_range(0, VOICES - 1)));
      else tick_voice(v);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = CMD_START;
    in_voice      = '0;
    in_start_pan  = '0;
    in_end_pan    = '0;
    in_duration   = '0;
    in_voice_vol  = '0;
    in_master_vol = '0;
    in_prog_vol   = '0;
    in_prog_pan   = '0;
    in_tone_vol   = '0;
    in_tone_pan   = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    words_sent    = 0;
    burst_left    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_mono(1'b0);

    // Directed: an idle voice ticks, and the top voice index and the first
    // index past the table are addressed.
    tick_voice(5'd0);
    send_word(CMD_START, 5'd24, 7'd0, 7'd127, 15'd5);
    tick_voice(5'd31);
    // Equal end points leave the voice untouched.
    send_word(CMD_START, 5'd1, 7'd50, 7'd50, 15'd10);
    // Zero duration jumps straight to the end.
    send_word(CMD_START, 5'd2, 7'd0, 7'd127, 15'd0);
    tick_voice(5'd2);
    // Full swing in one tick, and a downward ramp of big steps.
    send_word(CMD_START, 5'd23, 7'd127, 7'd0, 15'd1);
    tick_voice(5'd23);
    send_word(CMD_START, 5'd3, 7'd100, 7'd10, 15'd4);
    repeat (5) tick_voice(5'd3);
    // Slow ramp: one unit per step with a countdown between steps.
    send_word(CMD_START, 5'd4, 7'd60, 7'd63, 15'd9);
    repeat (9) tick_voice(5'd4);
    // Longest duration so every duration bit is set.
    send_word(CMD_START, 5'd5, 7'd1, 7'd0, 15'h7FFF);
    tick_voice(5'd5);

    set_mono(1'b1);
    send_word(CMD_START, 5'd6, 7'd0, 7'd127, 15'd2);
    repeat (3) tick_voice(5'd6);

    // Random part, with mode changes between phases.
    for (int phase = 0; phase < 6; phase++) begin
      set_mono(phase[0]);
      while (words_sent < 25 + (phase + 1) * 230) begin
        if ($urandom_range(0, 9) < 8) begin
          ramp_sequence();
        end else begin
          // Noise: any command on any voice index, in range or not.
          send_word(1'($urandom), 5'($urandom), 7'($urandom), 7'($urandom),
                    ($urandom_range(0, 1) != 0) ? 15'($urandom) : 15'($urandom_range(0, 30)));
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("Sent %0d command words in both mono settings, %0d of them stepped a pan.",
             words_sent, pan_steps);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which is well under a millisecond.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
